### rtl/core/btmx_pkg.sv
// Shared constants and types for the binary trie maximum-xor block.
package btmx_pkg;

    localparam int KEY_BITS = 32;
    localparam int NODES    = 65536;
    localparam int DATA_W   = 32;
    localparam int NODE_W   = $clog2(NODES);
    localparam int ENTRY_W  = 2 * NODE_W;
    localparam int LVL_W    = $clog2(KEY_BITS);

    localparam logic [NODE_W-1:0] NIL       = '0;
    localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                re;
        logic [NODE_W-1:0]   raddr;
        logic                we;
        logic [NODE_W-1:0]   waddr;
        logic [ENTRY_W-1:0]  wdata;
    } t_mem_req;

    typedef struct packed {
        logic [DATA_W-1:0] max_xor;
        logic              pool_full;
    } t_result;

endpackage

### rtl/core/btmx_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module btmx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/btmx_walk.sv
// Trie walker: one level per cycle, reads a node and, on an insert that adds a child, writes back its updated entry.
module btmx_walk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  btmx_pkg::t_cmd                      i_cmd,
    input  logic [btmx_pkg::DATA_W-1:0]         i_key,
    output logic                                o_idle,
    input  logic [btmx_pkg::ENTRY_W-1:0]        i_rd_data,
    output btmx_pkg::t_mem_req                  o_mem,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output btmx_pkg::t_result                   o_res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                            r_state,     n_state;
    btmx_pkg::t_cmd                    r_cmd,       n_cmd;
    logic [btmx_pkg::KEY_BITS-1:0]     r_key,       n_key;
    logic [btmx_pkg::LVL_W-1:0]        r_lvl,       n_lvl;
    logic [btmx_pkg::NODE_W-1:0]       r_node,      n_node;
    logic                              r_fresh,     n_fresh;
    logic [btmx_pkg::KEY_BITS-1:0]     r_acc,       n_acc;
    logic                              r_full,      n_full;
    logic [btmx_pkg::NODE_W-1:0]       r_next_free, n_next_free;
    logic                              r_root_ok,   n_root_ok;

    logic [btmx_pkg::ENTRY_W-1:0]      entry;
    logic [btmx_pkg::NODE_W-1:0]       child0;
    logic [btmx_pkg::NODE_W-1:0]       child1;
    logic [btmx_pkg::NODE_W-1:0]       same;
    logic [btmx_pkg::NODE_W-1:0]       other;
    logic [btmx_pkg::NODE_W-1:0]       new_node;
    logic                              key_bit;
    logic                              last;
    logic                              stop;
    btmx_pkg::t_mem_req                mem;

    // fresh nodes and a never-written root have no children yet
    always_comb begin
        if (r_fresh || (r_node == btmx_pkg::ROOT && !r_root_ok)) begin
            entry = '0;
        end else begin
            entry = i_rd_data;
        end
        child0   = entry[btmx_pkg::NODE_W-1:0];
        child1   = entry[btmx_pkg::ENTRY_W-1:btmx_pkg::NODE_W];
        key_bit  = r_key[r_lvl];
        same     = key_bit ? child1 : child0;
        other    = key_bit ? child0 : child1;
        new_node = btmx_pkg::NODE_W'(r_next_free + 1'b1);
        last     = (r_lvl == '0);
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_lvl       = r_lvl;
        n_node      = r_node;
        n_fresh     = r_fresh;
        n_acc       = r_acc;
        n_full      = r_full;
        n_next_free = r_next_free;
        mem         = '0;
        stop        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_cmd;
                    n_key     = btmx_pkg::KEY_BITS'(i_key);
                    n_lvl     = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
                    n_node    = btmx_pkg::ROOT;
                    n_fresh   = 1'b0;
                    n_acc     = '0;
                    n_full    = 1'b0;
                    mem.re    = 1'b1;
                    mem.raddr = btmx_pkg::ROOT;
                    n_state   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_cmd == btmx_pkg::CMD_INSERT) begin
                    if (same != btmx_pkg::NIL) begin
                        n_node    = same;
                        mem.re    = 1'b1;
                        mem.raddr = same;
                        stop      = last;
                    end else if (r_next_free == btmx_pkg::LAST_NODE) begin
                        stop   = 1'b1;
                        n_full = 1'b1;
                        // a node created by this insert was never written: empty it
                        if (r_fresh) begin
                            mem.we    = 1'b1;
                            mem.waddr = r_node;
                            mem.wdata = '0;
                        end
                    end else begin
                        mem.we      = 1'b1;
                        mem.waddr   = r_node;
                        mem.wdata   = key_bit ? {new_node, child0} : {child1, new_node};
                        n_next_free = new_node;
                        n_node      = new_node;
                        n_fresh     = 1'b1;
                        stop        = last;
                    end
                end else begin
                    if (other != btmx_pkg::NIL) begin
                        n_acc     = r_acc | (btmx_pkg::KEY_BITS'(1) << r_lvl);
                        n_node    = other;
                        mem.re    = 1'b1;
                        mem.raddr = other;
                        stop      = last;
                    end else if (same != btmx_pkg::NIL) begin
                        n_node    = same;
                        mem.re    = 1'b1;
                        mem.raddr = same;
                        stop      = last;
                    end else begin
                        stop = 1'b1;
                    end
                end
                if (stop) begin
                    n_state = i_res_ready ? ST_IDLE : ST_DONE;
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_root_ok = r_root_ok | (mem.we && mem.waddr == btmx_pkg::ROOT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next_free <= btmx_pkg::ROOT;
            r_root_ok   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_root_ok   <= n_root_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_lvl   <= n_lvl;
        r_node  <= n_node;
        r_fresh <= n_fresh;
        r_acc   <= n_acc;
        r_full  <= n_full;
    end

    assign o_idle            = (r_state == ST_IDLE);
    assign o_mem             = mem;
    assign o_res_valid       = (r_state == ST_WALK && stop) || (r_state == ST_DONE);
    assign o_res.max_xor     = btmx_pkg::DATA_W'(n_acc);
    assign o_res.pool_full   = n_full;

endmodule

### rtl/core/binary_trie_max_xor.sv
// Top level of the binary trie maximum-xor block: stream ports, node store, result register.
//
//  channel   | dir | tdata (low bit up)  | tuser (low bit up)
//  s_axis    | in  | key[31:0]           | cmd (0 insert, 1 query)
//  m_axis    | out | max_xor[31:0]       | pool_full
//
// An item first reads the root, then walks the trie level by level, each level's node
// read issued from the previous level's read data.
// An insert that runs out of nodes or a query that hits a dead end finishes early.
// The root reads empty until first written, so reset needs no clearing pass.
// A beat is accepted only while no walk is running; a result waiting in the output
// register does not block the next beat, but a second finished result waits for it.
module binary_trie_max_xor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [btmx_pkg::DATA_W-1:0] i_s_axis_tdata,   // key
    input  logic                        i_s_axis_tuser,   // cmd
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [btmx_pkg::DATA_W-1:0] o_m_axis_tdata,   // max_xor
    output logic                        o_m_axis_tuser    // pool_full
);

    btmx_pkg::t_mem_req                 mem;
    btmx_pkg::t_result                  res;
    logic [btmx_pkg::ENTRY_W-1:0]       rd_data;
    logic                               idle;
    logic                               res_valid;
    logic                               res_ready;

    logic                               r_m_valid;
    logic [btmx_pkg::DATA_W-1:0]        r_m_data;
    logic                               r_m_user;

    btmx_ram #(
        .WIDTH (btmx_pkg::ENTRY_W),
        .DEPTH (btmx_pkg::NODES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rd_data)
    );

    btmx_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_s_axis_tvalid && idle),
        .i_cmd       (btmx_pkg::t_cmd'(i_s_axis_tuser)),
        .i_key       (i_s_axis_tdata),
        .o_idle      (idle),
        .i_rd_data   (rd_data),
        .o_mem       (mem),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_data <= res.max_xor;
            r_m_user <= res.pool_full;
        end
    end

    assign o_s_axis_tready = idle;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

### rtl/core/btmx_chk.sv
// Port-level checker for the binary trie maximum-xor block, bound to the top level.
module btmx_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic [btmx_pkg::DATA_W-1:0] i_s_axis_tdata,
    input logic                        i_s_axis_tuser,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [btmx_pkg::DATA_W-1:0] o_m_axis_tdata,
    input logic                        o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again right after a beat");

    a_full_no_xor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("pool full flagged with nonzero max_xor");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared without a walk in progress");

endmodule

bind binary_trie_max_xor btmx_chk u_btmx_chk (.*);

### test/tb.sv
// Self-checking testbench for binary_trie_max_xor: stream traffic against a trie predictor.
`timescale 1ns / 1ps

module tb;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * (btmx_pkg::KEY_BITS + 1);
    localparam int RANDOM_ITEMS = 200;
    localparam int FILL_ITEMS = 40;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_s_axis_tvalid = 1'b0;
    logic                        o_s_axis_tready;
    logic [btmx_pkg::DATA_W-1:0] i_s_axis_tdata = '0;   // key
    logic                        i_s_axis_tuser = 1'b0; // cmd
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready = 1'b0;
    logic [btmx_pkg::DATA_W-1:0] o_m_axis_tdata;        // max_xor
    logic                        o_m_axis_tuser;        // pool_full

    binary_trie_max_xor uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // trie mirror
    int unsigned          trie_kids [0:btmx_pkg::NODES-1][0:1];
    int unsigned          top_node = 1;
    logic [31:0]          stored_keys[$];
    btmx_pkg::t_result    pending_results[$];

    int                   err_count = 0;
    int                   idle_pct = 0;
    int                   stall_pct = 0;
    int                   hold_req = 0;
    int                   hold_ack = 0;
    int                   hold_left = 0;
    int                   quiet_cycles = 0;
    btmx_pkg::t_result    want;

    function automatic bit trie_insert(logic [31:0] k);
        int unsigned u;
        int          lvl;
        bit          b;
        u = 1;
        for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            b = k[lvl];
            if (trie_kids[u][b] == 0) begin
                if (top_node + 1 >= btmx_pkg::NODES)
                    return 1'b1;
                top_node++;
                trie_kids[u][b] = top_node;
            end
            u = trie_kids[u][b];
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] best_xor(logic [31:0] k);
        int unsigned u;
        int          lvl;
        bit          b;
        logic [31:0] acc;
        u   = 1;
        acc = '0;
        for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            b = k[lvl];
            if (trie_kids[u][!b] != 0) begin
                acc[lvl] = 1'b1;
                u = trie_kids[u][!b];
            end else if (trie_kids[u][b] != 0) begin
                u = trie_kids[u][b];
            end else begin
                break;
            end
        end
        return acc;
    endfunction

    function automatic logic [31:0] pick_key();
        logic [31:0] base;
        int          mode;
        mode = $urandom_range(9);
        if (stored_keys.size() == 0 || mode < 4)
            return $urandom();
        base = stored_keys[$urandom_range(stored_keys.size() - 1)];
        case (mode)
            4, 5: return base ^ (32'd1 << $urandom_range(31));
            6:    return base ^ ($urandom() & ((32'd1 << $urandom_range(31)) - 1));
            7:    return ~base;
            8:    return base;
            default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // one beat in; the expected result is queued at acceptance
    task automatic send_item(input btmx_pkg::t_cmd op, input logic [31:0] k);
        btmx_pkg::t_result r;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= k;
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        r.max_xor   = '0;
        r.pool_full = 1'b0;
        if (op == btmx_pkg::CMD_INSERT) begin
            r.pool_full = trie_insert(k);
            if (!r.pool_full)
                stored_keys.push_back(k);
        end else begin
            r.max_xor = best_xor(k);
        end
        pending_results.push_back(r);
    endtask

    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(btmx_pkg::CMD_QUERY,  32'h0000_0000);
        send_item(btmx_pkg::CMD_QUERY,  32'hFFFF_FFFF);
        send_item(btmx_pkg::CMD_INSERT, 32'h0000_0000);
        send_item(btmx_pkg::CMD_QUERY,  32'h0000_0000);
        send_item(btmx_pkg::CMD_QUERY,  32'hFFFF_FFFF);
        send_item(btmx_pkg::CMD_INSERT, 32'h0000_0000);
        send_item(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_item(btmx_pkg::CMD_QUERY,  32'h0000_0000);
        send_item(btmx_pkg::CMD_QUERY,  32'h8000_0000);
        send_item(btmx_pkg::CMD_INSERT, 32'h8000_0000);
        send_item(btmx_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        send_item(btmx_pkg::CMD_QUERY,  32'h8000_0000);
        send_item(btmx_pkg::CMD_QUERY,  32'h7FFF_FFFF);
        send_item(btmx_pkg::CMD_INSERT, 32'h0000_0001);
        send_item(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFE);
        send_item(btmx_pkg::CMD_QUERY,  32'h0000_0001);
        send_item(btmx_pkg::CMD_INSERT, 32'h5555_5555);
        send_item(btmx_pkg::CMD_INSERT, 32'hAAAA_AAAA);
        send_item(btmx_pkg::CMD_QUERY,  32'h5555_5555);
        send_item(btmx_pkg::CMD_QUERY,  32'hAAAA_AAAA);
        send_item(btmx_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_item(btmx_pkg::CMD_QUERY,  32'hFFFF_FFFE);
    endtask

    task automatic test_random_traffic(input int src_idle, input int dst_stall);
        int n;
        idle_pct  = src_idle;
        stall_pct = dst_stall;
        for (n = 0; n < RANDOM_ITEMS; n++)
            send_item($urandom_range(1) ? btmx_pkg::CMD_QUERY : btmx_pkg::CMD_INSERT,
                      pick_key());
    endtask

    task automatic test_backpressure();
        int n;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req <= hold_req + 1;
        for (n = 0; n < 30; n++)
            send_item($urandom_range(1) ? btmx_pkg::CMD_QUERY : btmx_pkg::CMD_INSERT,
                      pick_key());
    endtask

    task automatic test_fill();
        int n;
        idle_pct  = 7;
        stall_pct = 7;
        // fresh random keys build long new paths
        for (n = 0; n < FILL_ITEMS; n++) begin
            send_item(btmx_pkg::CMD_INSERT, $urandom());
            if (n % 8 == 0)
                send_item(btmx_pkg::CMD_QUERY, $urandom());
        end
        send_item(btmx_pkg::CMD_INSERT, stored_keys[0]);
        send_item(btmx_pkg::CMD_INSERT, stored_keys[stored_keys.size() - 1]);
        for (n = 0; n < 20; n++)
            send_item($urandom_range(1) ? btmx_pkg::CMD_QUERY : btmx_pkg::CMD_INSERT,
                      pick_key());
    endtask

    // result sink
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected beat: max_xor=%h pool_full=%b",
                                     o_m_axis_tdata, o_m_axis_tuser));
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata !== want.max_xor || o_m_axis_tuser !== want.pool_full)
                    note_error($sformatf("mismatch: max_xor exp %h got %h, full exp %b got %b",
                                         want.max_xor, o_m_axis_tdata,
                                         want.pool_full, o_m_axis_tuser));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_traffic(0, 0);
        test_random_traffic(73, 0);
        test_random_traffic(0, 73);
        test_random_traffic(7, 7);
        test_backpressure();
        test_fill();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        err_count += pending_results.size();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
